/* src/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lc_pkg.sv */
package lc_pkg;

  // Response store size and derived widths
  localparam int MAX_TAPS = 32;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Sample, product and accumulator widths
  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int ACC_W  = 40;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input mode codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SAMPLE,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [SMP_W-1:0] value;
    logic                    last;
  } lc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lc_qstat_t;

endpackage

/* src/lc_queue.sv */
module lc_queue
  import lc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lc_item_t  push_item_i,
  input  logic      pop_i,
  output lc_item_t  pop_item_o,
  output lc_qstat_t stat_o
);

  lc_item_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* src/lc_front.sv */
module lc_front
  import lc_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [SMP_W-1:0] sample_value_i,
  input  logic              last_item_i,
  input  lc_qstat_t         qstat_i,
  output logic              push_o,
  output lc_item_t          push_item_o
);

  logic accept;
  logic known;

  // Hold the input off while the queue is full
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;

  // Classify the transaction; drop unknown modes
  always_comb begin
    known            = 1'b1;
    push_item_o.cmd   = CMD_SAMPLE;
    push_item_o.value = sample_value_i;
    push_item_o.last  = last_item_i;
    unique case (mode_i)
      MODE_LOAD:   push_item_o.cmd = CMD_LOAD;
      MODE_SAMPLE: push_item_o.cmd = CMD_SAMPLE;
      MODE_CLEAR:  push_item_o.cmd = CMD_CLEAR;
      default:     known = 1'b0;
    endcase
  end

  assign push_o = accept && known;

endmodule

/* src/lc_back.sv */
module lc_back
  import lc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lc_qstat_t               qstat_i,
  input  lc_item_t                item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] out_value_o,
  output logic                    last_result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } st_e;

  st_e                      state_q, state_d;
  logic [CNT_W-1:0]         tap_cnt_q, tap_cnt_d;
  logic [CNT_W-1:0]         extra_q, extra_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic                     last_q, last_d;
  logic                     v1_q, v1_d, v2_q, v2_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q;
  logic signed [ACC_W-1:0]  out_value_q;
  logic                     out_last_q;
  logic signed [SMP_W-1:0]  dline_q [MAX_TAPS];

  logic signed [SMP_W-1:0]  coef_mem [MAX_TAPS];
  logic signed [SMP_W-1:0]  coef_rd_q, dly_q;
  logic signed [PROD_W-1:0] prod_q;

  logic                     issue, mem_we, shift_en, clr_dline, out_load, out_taken;
  logic signed [SMP_W-1:0]  shift_val;

  assign issue     = (k_q < tap_cnt_q);
  assign out_taken = out_valid_q && !out_stall_i;

  // Sequence commands and the tap walk
  always_comb begin
    state_d   = state_q;
    tap_cnt_d = tap_cnt_q;
    extra_d   = extra_q;
    k_d       = k_q;
    last_d    = last_q;
    v1_d      = 1'b0;
    v2_d      = 1'b0;
    acc_d     = acc_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    shift_en  = 1'b0;
    shift_val = '0;
    clr_dline = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          unique case (item_i.cmd)
            CMD_LOAD: begin
              if (tap_cnt_q < CNT_W'(MAX_TAPS)) begin
                mem_we    = 1'b1;
                tap_cnt_d = tap_cnt_q + 1'b1;
              end
            end
            CMD_CLEAR: begin
              tap_cnt_d = '0;
            end
            CMD_SAMPLE: begin
              shift_en  = 1'b1;
              shift_val = item_i.value;
              last_d    = item_i.last;
              extra_d   = (item_i.last && tap_cnt_q != '0) ? tap_cnt_q - 1'b1 : '0;
              k_d       = '0;
              acc_d     = '0;
              state_d   = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        v1_d = issue;
        v2_d = v1_q;
        if (v2_q) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        if (!issue && !v1_q && !v2_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_taken) begin
          out_load = 1'b1;
          if (extra_q != '0) begin
            // Flush with a zero sample for the tail of the sequence
            extra_d  = extra_q - 1'b1;
            shift_en = 1'b1;
            k_d      = '0;
            acc_d    = '0;
            state_d  = ST_RUN;
          end else begin
            clr_dline = last_q;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_cnt_q   <= '0;
      extra_q     <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_cnt_q <= tap_cnt_d;
      extra_q   <= extra_d;
      k_q       <= k_d;
      last_q    <= last_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      acc_q     <= acc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delay line: shift in at entry 0, clear after a sequence ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        dline_q[i] <= '0;
      end
    end else if (clr_dline) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        dline_q[i] <= '0;
      end
    end else if (shift_en) begin
      dline_q[0] <= shift_val;
      for (int i = 1; i < MAX_TAPS; i++) begin
        dline_q[i] <= dline_q[i-1];
      end
    end
  end

  // Coefficient store, operand fetch and multiply
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[tap_cnt_q[TAP_W-1:0]] <= item_i.value;
    end
    coef_rd_q <= coef_mem[k_q[TAP_W-1:0]];
    dly_q     <= dline_q[k_q[TAP_W-1:0]];
    prod_q    <= PROD_W'(coef_rd_q) * PROD_W'(dly_q);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= acc_q;
      out_last_q  <= last_q && (extra_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign last_result_o = out_last_q;

endmodule

/* src/linear_convolution.sv */
// Full linear convolution of a Q1.15 sample stream with a loaded response of up
// to 32 Q1.15 coefficients, giving Q10.30 sums. Mode 0 transactions append a
// coefficient (ignored once the store is full), mode 2 empties the response,
// mode 1 pushes a sample and yields one sum; a sample marked last also yields
// tap_count-1 tail sums over zero samples, the final one marked last, and the
// delay line is then cleared. Mode 3 is accepted and dropped. Transactions
// enter a four-entry command queue, so input keeps flowing while results wait, until the queue is full.
// Loads and clears are taken from the queue in the idle state. With a loaded
// response a single shared multiply-accumulate walks the coefficient store one
// tap per cycle through the operand registers, the product register and the
// accumulator; the sequencer then sees the walk done and hands the sum to the
// output register. A sample's first sum also waits for its command to leave the
// queue, and a sum the receiver still holds stalls the next one.
module linear_convolution
  import lc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic signed [SMP_W-1:0] sample_value_i,
  input  logic                    last_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] out_value_o,
  output logic                    last_result_o
);

  lc_qstat_t qstat;
  logic      push, pop;
  lc_item_t  push_item, pop_item;

  lc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .sample_value_i (sample_value_i),
    .last_item_i    (last_item_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  lc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (qstat)
  );

  lc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_value_o   (out_value_o),
    .last_result_o (last_result_o)
  );

endmodule

/* src/lc_checker.sv */
`include "assert_macros.svh"

module lc_checker
  import lc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [ACC_W-1:0] out_value_o,
  input logic                    last_result_o
);

  logic           out_held;
  logic           out_fits;
  logic [ACC_W:0] out_word;

  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {out_value_o, last_result_o};
  assign out_fits = (out_value_o[ACC_W-1:ACC_W-4] == 4'h0) ||
                    (out_value_o[ACC_W-1:ACC_W-4] == 4'hF);

  // A stalled result stays offered
  `ASSERT_CLK(a_out_valid_hold, clk_i, rst_ni, out_held |=> out_valid_o, "result dropped")

  // A stalled result keeps its payload
  `ASSERT_CLK(a_out_data_hold, clk_i, rst_ni, out_held |=> $stable(out_word), "result changed")

  // Sums of at most 32 Q2.30 products fit in 37 bits
  `ASSERT_CLK(a_out_range, clk_i, rst_ni, out_valid_o |-> out_fits, "sum exceeds its range")

  // No result is offered as reset is released
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, $rose(rst_ni) |-> !out_valid_o, "result out of reset")

endmodule

bind linear_convolution lc_checker u_lc_checker (.*);
